// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the tile halo neighbor test.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/thof_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile halo neighbor test package
// Edge codes, register indexes, result widths and the classification record.
// ----------------------------------------------------------------------------
package thof_pkg;

  localparam int EDGE_W   = 3;
  localparam int OFFSET_W = 18;
  localparam int COUNT_W  = 16;
  localparam int RESULT_W = EDGE_W + OFFSET_W + COUNT_W;
  localparam int QUEUE_DEPTH = 2;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_OWN_POS_X  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OWN_POS_Y  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OWN_SIZE_X = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_OWN_SIZE_Y = 2'd3;

  typedef enum logic [EDGE_W-1:0] {
    EDGE_NONE   = 3'd0,
    EDGE_TOP    = 3'd1,
    EDGE_RIGHT  = 3'd2,
    EDGE_BOTTOM = 3'd3,
    EDGE_LEFT   = 3'd4
  } edge_t;

  typedef struct packed {
    edge_t shared_edge;
    logic  start_in;
    logic  end_in;
  } thof_class_t;

endpackage

// ===== design/tile_halo_overlap_offset_top.sv =====
// ----------------------------------------------------------------------------
// Tile halo neighbor test, top level
// Reports the edge a neighbor tile shares with the own tile, its halo offset
// and its shared point count.
// ----------------------------------------------------------------------------
// Usage: the own tile's position and size are written through the cfg port
// while the block is idle. Neighbor descriptors enter through a queue-like
// port: a transfer takes place at a clock edge with push high and full low.
// Results leave the same way: the oldest result is on the out_ ports while
// empty is low, and a transfer takes place at an edge with pop high.
// A front stage classifies each descriptor into a two-entry queue, and a back
// stage computes offset and count into a two-entry result queue.
// A result becomes visible only after its item passes both queues.
// Throughput: one descriptor per cycle while results are taken every cycle.
// When the receiver stalls, the result queue and then the classified queue
// fill, and full rises after four items are held. Reset clears both queues
// and sets the own tile to position zero and size one.
// ----------------------------------------------------------------------------
module tile_halo_overlap_offset_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [thof_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [COORD_BITS-1:0]          cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic [COORD_BITS-1:0]          in_nbr_pos_x,
  input  logic [COORD_BITS-1:0]          in_nbr_pos_y,
  input  logic [COORD_BITS-1:0]          in_nbr_size_x,
  input  logic [COORD_BITS-1:0]          in_nbr_size_y,
  output logic                           empty,
  input  logic                           pop,
  output logic [thof_pkg::EDGE_W-1:0]    out_shared_edge,
  output logic [thof_pkg::OFFSET_W-1:0]  out_halo_offset,
  output logic [thof_pkg::COUNT_W-1:0]   out_overlap_count
);
  import thof_pkg::*;

  localparam int CLSW = $bits(thof_class_t);
  localparam int QW   = CLSW + 2 * COORD_BITS;

  logic [COORD_BITS-1:0] own_pos_x_r, own_pos_y_r, own_size_x_r, own_size_y_r;

  thof_class_t           cls_f, cls_b;
  logic [COORD_BITS-1:0] seg_pos_f, seg_size_f, seg_pos_b, seg_size_b;
  logic [QW-1:0]         q_din, q_dout;
  logic                  q_push, q_pop, q_full, q_empty;

  logic [EDGE_W-1:0]     res_edge;
  logic [OFFSET_W-1:0]   res_offset;
  logic [COUNT_W-1:0]    res_count;
  logic [RESULT_W-1:0]   o_din, o_dout;
  logic                  o_pop, o_full, o_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_pos_x_r  <= '0;
      own_pos_y_r  <= '0;
      own_size_x_r <= COORD_BITS'(1);
      own_size_y_r <= COORD_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OWN_POS_X:  own_pos_x_r  <= cfg_wdata;
        REG_OWN_POS_Y:  own_pos_y_r  <= cfg_wdata;
        REG_OWN_SIZE_X: own_size_x_r <= cfg_wdata;
        REG_OWN_SIZE_Y: own_size_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  thof_front #(.COORD_BITS(COORD_BITS)) u_front (
    .own_pos_x  (own_pos_x_r),
    .own_pos_y  (own_pos_y_r),
    .own_size_x (own_size_x_r),
    .own_size_y (own_size_y_r),
    .nbr_pos_x  (in_nbr_pos_x),
    .nbr_pos_y  (in_nbr_pos_y),
    .nbr_size_x (in_nbr_size_x),
    .nbr_size_y (in_nbr_size_y),
    .cls        (cls_f),
    .seg_pos    (seg_pos_f),
    .seg_size   (seg_size_f)
  );

  assign q_push = push && !q_full;
  assign q_pop  = !q_empty && !o_full;
  assign q_din  = {cls_f, seg_pos_f, seg_size_f};

  thof_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_class_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign cls_b      = thof_class_t'(q_dout[QW-1 -: CLSW]);
  assign seg_pos_b  = q_dout[2*COORD_BITS-1 -: COORD_BITS];
  assign seg_size_b = q_dout[COORD_BITS-1:0];

  thof_back #(.COORD_BITS(COORD_BITS)) u_back (
    .own_pos_x     (own_pos_x_r),
    .own_pos_y     (own_pos_y_r),
    .own_size_x    (own_size_x_r),
    .own_size_y    (own_size_y_r),
    .cls           (cls_b),
    .seg_pos       (seg_pos_b),
    .seg_size      (seg_size_b),
    .shared_edge   (res_edge),
    .halo_offset   (res_offset),
    .overlap_count (res_count)
  );

  assign o_din = {res_edge, res_offset, res_count};
  assign o_pop = pop && !o_empty;

  thof_fifo #(.WIDTH(RESULT_W), .DEPTH(QUEUE_DEPTH)) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_pop),
    .din   (o_din),
    .pop   (o_pop),
    .dout  (o_dout),
    .full  (o_full),
    .empty (o_empty)
  );

  assign full              = q_full;
  assign empty             = o_empty;
  assign out_shared_edge   = o_dout[RESULT_W-1 -: EDGE_W];
  assign out_halo_offset   = o_dout[COUNT_W+OFFSET_W-1 -: OFFSET_W];
  assign out_overlap_count = o_dout[COUNT_W-1:0];

endmodule

// ===== design/thof_fifo.sv =====
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out queue of a few entries with registered occupancy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thof_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign dout  = slot_r[rd_ptr_r];
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  `ASSERT_RST(a_count_bound, clk, rst_n, (count_r <= CW'(DEPTH)), "queue count overflow")
  `ASSERT_RST(a_push_grows, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "queue push lost")
  `ASSERT_RST(a_pop_shrinks, clk, rst_n, (pop && !push) |=> (count_r == $past(count_r) - 1'b1), "queue pop lost")

endmodule

// ===== design/thof_front.sv =====
// ----------------------------------------------------------------------------
// Tile halo front end
// Classifies a neighbor tile by the edge it shares with the own tile.
// ----------------------------------------------------------------------------
module thof_front #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0] own_pos_x,
  input  logic [COORD_BITS-1:0] own_pos_y,
  input  logic [COORD_BITS-1:0] own_size_x,
  input  logic [COORD_BITS-1:0] own_size_y,
  input  logic [COORD_BITS-1:0] nbr_pos_x,
  input  logic [COORD_BITS-1:0] nbr_pos_y,
  input  logic [COORD_BITS-1:0] nbr_size_x,
  input  logic [COORD_BITS-1:0] nbr_size_y,
  output thof_pkg::thof_class_t cls,
  output logic [COORD_BITS-1:0] seg_pos,
  output logic [COORD_BITS-1:0] seg_size
);
  import thof_pkg::*;

  localparam int SW = COORD_BITS + 1;

  logic [SW-1:0] ox0, oxe, oy0, oye;
  logic [SW-1:0] nx0, nxe, ny0, nye;
  logic [SW-1:0] own_p, own_e, nbr_p, nbr_e;
  logic          touch_x, touch_y, use_y;
  edge_t         edge_sel;

  assign ox0 = SW'(own_pos_x);
  assign oxe = SW'(own_pos_x) + SW'(own_size_x);
  assign oy0 = SW'(own_pos_y);
  assign oye = SW'(own_pos_y) + SW'(own_size_y);
  assign nx0 = SW'(nbr_pos_x);
  assign nxe = SW'(nbr_pos_x) + SW'(nbr_size_x);
  assign ny0 = SW'(nbr_pos_y);
  assign nye = SW'(nbr_pos_y) + SW'(nbr_size_y);

  assign touch_x = (nx0 >= ox0 && nx0 < oxe) || (nxe > ox0 && nxe <= oxe) ||
                   (ox0 >= nx0 && ox0 < nxe) || (oxe > nx0 && oxe <= nxe);
  assign touch_y = (ny0 >= oy0 && ny0 < oye) || (nye > oy0 && nye <= oye) ||
                   (oy0 >= ny0 && oy0 < nye) || (oye > ny0 && oye <= nye);

  always_comb begin
    edge_sel = EDGE_NONE;
    if (touch_x) begin
      if (oye == ny0) begin
        edge_sel = EDGE_BOTTOM;
      end else if (oy0 == nye) begin
        edge_sel = EDGE_TOP;
      end
    end else if (touch_y) begin
      if (oxe == nx0) begin
        edge_sel = EDGE_RIGHT;
      end else if (ox0 == nxe) begin
        edge_sel = EDGE_LEFT;
      end
    end
  end

  assign use_y = (edge_sel == EDGE_RIGHT) || (edge_sel == EDGE_LEFT);
  assign own_p = use_y ? oy0 : ox0;
  assign own_e = use_y ? oye : oxe;
  assign nbr_p = use_y ? ny0 : nx0;
  assign nbr_e = use_y ? nye : nxe;

  assign cls.shared_edge = edge_sel;
  assign cls.start_in    = (nbr_p >= own_p);
  assign cls.end_in      = (nbr_e <= own_e);
  assign seg_pos  = use_y ? nbr_pos_y : nbr_pos_x;
  assign seg_size = use_y ? nbr_size_y : nbr_size_x;

endmodule

// ===== design/thof_back.sv =====
// ----------------------------------------------------------------------------
// Tile halo back end
// Computes the halo buffer offset and shared point count of a classified item.
// ----------------------------------------------------------------------------
module thof_back #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0]         own_pos_x,
  input  logic [COORD_BITS-1:0]         own_pos_y,
  input  logic [COORD_BITS-1:0]         own_size_x,
  input  logic [COORD_BITS-1:0]         own_size_y,
  input  thof_pkg::thof_class_t         cls,
  input  logic [COORD_BITS-1:0]         seg_pos,
  input  logic [COORD_BITS-1:0]         seg_size,
  output logic [thof_pkg::EDGE_W-1:0]   shared_edge,
  output logic [thof_pkg::OFFSET_W-1:0] halo_offset,
  output logic [thof_pkg::COUNT_W-1:0]  overlap_count
);
  import thof_pkg::*;

  localparam int XW   = COORD_BITS + 2;
  localparam int OFFW = (XW > OFFSET_W) ? XW : OFFSET_W;
  localparam int CNTW = (XW > COUNT_W) ? XW : COUNT_W;

  logic                  use_y, active;
  logic [COORD_BITS-1:0] own_p, own_s;
  logic [XW-1:0]         own_e, nbr_e, base, off_seg, off_full, cnt_raw, cnt_pos;
  logic [OFFW-1:0]       off_ext;
  logic [CNTW-1:0]       cnt_ext;

  assign use_y  = (cls.shared_edge == EDGE_RIGHT) || (cls.shared_edge == EDGE_LEFT);
  assign active = (cls.shared_edge != EDGE_NONE);
  assign own_p  = use_y ? own_pos_y : own_pos_x;
  assign own_s  = use_y ? own_size_y : own_size_x;
  assign own_e  = XW'(own_p) + XW'(own_s);
  assign nbr_e  = XW'(seg_pos) + XW'(seg_size);

  always_comb begin
    case (cls.shared_edge)
      EDGE_RIGHT:  base = XW'(own_size_x);
      EDGE_LEFT:   base = XW'(own_size_x) + XW'(own_size_y);
      EDGE_BOTTOM: base = XW'(own_size_x) + (XW'(own_size_y) << 1);
      default:     base = '0;
    endcase
  end

  always_comb begin
    if (cls.start_in && cls.end_in) begin
      cnt_raw = XW'(seg_size);
    end else if (cls.start_in) begin
      cnt_raw = own_e - XW'(seg_pos);
    end else if (cls.end_in) begin
      cnt_raw = nbr_e - XW'(own_p);
    end else begin
      cnt_raw = XW'(own_s);
    end
  end

  assign off_seg  = cls.start_in ? (XW'(seg_pos) - XW'(own_p)) : '0;
  assign off_full = off_seg + base;
  assign cnt_pos  = cnt_raw[XW-1] ? '0 : cnt_raw;
  assign off_ext  = OFFW'(off_full);
  assign cnt_ext  = CNTW'(cnt_pos);

  assign shared_edge   = cls.shared_edge;
  assign halo_offset   = active ? off_ext[OFFSET_W-1:0] : '0;
  assign overlap_count = active ? cnt_ext[COUNT_W-1:0] : '0;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile halo neighbor test bench
// Writes the own tile through the cfg port, sends directed and random
// neighbor descriptors and compares every result with an expectation that a
// scoreboard works out from the own tile and the descriptor, under random
// idling on both sides, a long receiver stall and a full drain.
// ----------------------------------------------------------------------------
module testbench;
  import thof_pkg::*;

  localparam int CW = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 90;
  localparam int PHASES = 7;
  localparam logic [REG_IDX_W-1:0] REG_ORDER [4] = '{
    REG_OWN_POS_X, REG_OWN_POS_Y, REG_OWN_SIZE_X, REG_OWN_SIZE_Y
  };

  typedef struct packed {
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic [CW-1:0] size_x;
    logic [CW-1:0] size_y;
  } nbr_t;

  typedef struct packed {
    edge_t                shared_edge;
    logic [OFFSET_W-1:0]  halo_offset;
    logic [COUNT_W-1:0]   overlap_count;
  } halo_t;

  class halo_scoreboard;
    logic [CW-1:0] own_pos_x = '0;
    logic [CW-1:0] own_pos_y = '0;
    logic [CW-1:0] own_size_x = CW'(1);
    logic [CW-1:0] own_size_y = CW'(1);
    halo_t expected_halos [$];
    int errors = 0;

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] val);
      case (idx)
        REG_OWN_POS_X:  own_pos_x = val;
        REG_OWN_POS_Y:  own_pos_y = val;
        REG_OWN_SIZE_X: own_size_x = val;
        REG_OWN_SIZE_Y: own_size_y = val;
        default: ;
      endcase
    endfunction

    function bit spans_touch(longint a0, longint a1, longint b0, longint b1);
      return (b0 >= a0 && b0 <= a1) || (b1 >= a0 && b1 <= a1) ||
             (a0 >= b0 && a0 <= b1) || (a1 >= b0 && a1 <= b1);
    endfunction

    function void edge_segment(input longint p, input longint s, input longint tp,
                               input longint ts, output longint off, output longint cnt);
      longint e, te;
      e = p + s;
      te = tp + ts;
      if (tp >= p && te <= e) begin
        off = tp - p;
        cnt = te - tp;
      end else if (tp >= p) begin
        off = tp - p;
        cnt = e - tp;
      end else if (te <= e) begin
        off = 0;
        cnt = te - p;
      end else begin
        off = 0;
        cnt = s;
      end
    endfunction

    function halo_t classify_neighbor(nbr_t n);
      longint px, py, sx, sy, tx, ty, tsx, tsy, ex, ey, tex, tey, off, cnt;
      halo_t r;
      px = own_pos_x;
      py = own_pos_y;
      sx = own_size_x;
      sy = own_size_y;
      tx = n.pos_x;
      ty = n.pos_y;
      tsx = n.size_x;
      tsy = n.size_y;
      ex = px + sx - 1;
      ey = py + sy - 1;
      tex = tx + tsx - 1;
      tey = ty + tsy - 1;
      off = 0;
      cnt = 0;
      r.shared_edge = EDGE_NONE;
      if (spans_touch(px, ex, tx, tex)) begin
        if (ey + 1 == ty) r.shared_edge = EDGE_BOTTOM;
        else if (py == tey + 1) r.shared_edge = EDGE_TOP;
      end else if (spans_touch(py, ey, ty, tey)) begin
        if (ex + 1 == tx) r.shared_edge = EDGE_RIGHT;
        else if (px == tex + 1) r.shared_edge = EDGE_LEFT;
      end
      case (r.shared_edge)
        EDGE_TOP: edge_segment(px, sx, tx, tsx, off, cnt);
        EDGE_RIGHT: begin
          edge_segment(py, sy, ty, tsy, off, cnt);
          off += sx;
        end
        EDGE_BOTTOM: begin
          edge_segment(px, sx, tx, tsx, off, cnt);
          off += sx + 2 * sy;
        end
        EDGE_LEFT: begin
          edge_segment(py, sy, ty, tsy, off, cnt);
          off += sx + sy;
        end
        default: ;
      endcase
      if (off < 0) off = 0;
      if (cnt < 0) cnt = 0;
      r.halo_offset = off[OFFSET_W-1:0];
      r.overlap_count = cnt[COUNT_W-1:0];
      return r;
    endfunction

    function void note_neighbor(nbr_t n);
      expected_halos.push_back(classify_neighbor(n));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_halo(halo_t got);
      halo_t want;
      if (expected_halos.size() == 0) begin
        report_mismatch($sformatf("result edge %0d offset %0d count %0d with none expected",
                                  got.shared_edge, got.halo_offset, got.overlap_count));
        return;
      end
      want = expected_halos.pop_front();
      if (got.shared_edge !== want.shared_edge)
        report_mismatch($sformatf("shared_edge got %0d, want %0d",
                                  got.shared_edge, want.shared_edge));
      if (got.halo_offset !== want.halo_offset)
        report_mismatch($sformatf("halo_offset got %0d, want %0d",
                                  got.halo_offset, want.halo_offset));
      if (got.overlap_count !== want.overlap_count)
        report_mismatch($sformatf("overlap_count got %0d, want %0d",
                                  got.overlap_count, want.overlap_count));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = REG_OWN_POS_X;
  logic [CW-1:0]        cfg_wdata = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [CW-1:0]        in_nbr_pos_x = '0;
  logic [CW-1:0]        in_nbr_pos_y = '0;
  logic [CW-1:0]        in_nbr_size_x = '0;
  logic [CW-1:0]        in_nbr_size_y = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [EDGE_W-1:0]    out_shared_edge;
  logic [OFFSET_W-1:0]  out_halo_offset;
  logic [COUNT_W-1:0]   out_overlap_count;

  halo_scoreboard halos;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycle_count = 0;

  tile_halo_overlap_offset_top #(.COORD_BITS(CW)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_nbr_pos_x      (in_nbr_pos_x),
    .in_nbr_pos_y      (in_nbr_pos_y),
    .in_nbr_size_x     (in_nbr_size_x),
    .in_nbr_size_y     (in_nbr_size_y),
    .empty             (empty),
    .pop               (pop),
    .out_shared_edge   (out_shared_edge),
    .out_halo_offset   (out_halo_offset),
    .out_overlap_count (out_overlap_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin : result_side
    halo_t got;
    if (pop && !empty) begin
      got = {out_shared_edge, out_halo_offset, out_overlap_count};
      halos.check_halo(got);
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [CW-1:0] random_size();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 10) return '1;
    if (r < 25) return CW'($urandom);
    return CW'($urandom_range(64, 1));
  endfunction

  function automatic bit fits(longint v);
    return v >= 0 && v <= 65535;
  endfunction

  // Most neighbors are placed against one side of the own tile with a random
  // overlap along it; some are moved one point off, the rest are uniform.
  function automatic nbr_t random_neighbor();
    longint p_along, s_along, p_across, s_across;
    longint n_along, n_along_size, n_across, n_across_size, span_max;
    int kind, side;
    nbr_t n;
    n = {CW'($urandom), CW'($urandom), random_size(), random_size()};
    kind = $urandom_range(99);
    if (kind < 85) begin
      side = $urandom_range(3);
      if (side < 2) begin
        p_along = halos.own_pos_x;
        s_along = halos.own_size_x;
        p_across = halos.own_pos_y;
        s_across = halos.own_size_y;
      end else begin
        p_along = halos.own_pos_y;
        s_along = halos.own_size_y;
        p_across = halos.own_pos_x;
        s_across = halos.own_size_x;
      end
      span_max = (2 * s_along + 4 > 65535) ? 65535 : 2 * s_along + 4;
      if ($urandom_range(3) == 0) n_along_size = random_size();
      else n_along_size = longint'($urandom_range(int'(span_max), 1));
      n_along = p_along - longint'($urandom_range(int'(n_along_size), 0)) +
                longint'($urandom_range(int'(s_along), 0));
      n_across_size = random_size();
      if (side % 2 == 0) n_across = p_across - n_across_size;
      else n_across = p_across + s_across;
      if (kind >= 70) n_across += ($urandom_range(1) == 1) ? 1 : -1;
      if (fits(n_along) && fits(n_across)) begin
        if (side < 2)
          n = {CW'(n_along), CW'(n_across), CW'(n_along_size), CW'(n_across_size)};
        else
          n = {CW'(n_across), CW'(n_along), CW'(n_across_size), CW'(n_along_size)};
      end
    end
    return n;
  endfunction

  task automatic set_own_tile(input logic [CW-1:0] px, input logic [CW-1:0] py,
                              input logic [CW-1:0] sx, input logic [CW-1:0] sy);
    logic [CW-1:0] vals [4];
    vals = '{px, py, sx, sy};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      halos.write_reg(REG_ORDER[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic offer(input nbr_t n);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_nbr_pos_x <= n.pos_x;
    in_nbr_pos_y <= n.pos_y;
    in_nbr_size_x <= n.size_x;
    in_nbr_size_y <= n.size_y;
    do @(posedge clk); while (full);
    halos.note_neighbor(n);
  endtask

  task automatic offer_at(input int x, input int y, input int w, input int h);
    offer({CW'(x), CW'(y), CW'(w), CW'(h)});
  endtask

  task automatic drain();
    push <= 1'b0;
    while (halos.expected_halos.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    halos = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_at(1, 0, 1, 1);
    offer_at(0, 1, 1, 1);
    offer_at(65535, 65535, 65535, 65535);
    offer_at(0, 0, 1, 1);
    drain();

    set_own_tile(100, 200, 50, 40);
    offer_at(110, 190, 10, 10);
    offer_at(90, 150, 20, 50);
    offer_at(140, 180, 30, 20);
    offer_at(0, 0, 65535, 200);
    offer_at(120, 240, 5, 5);
    offer_at(150, 210, 10, 10);
    offer_at(90, 195, 10, 100);
    offer_at(150, 240, 5, 5);
    offer_at(110, 210, 5, 5);
    offer_at(120, 240, 0, 5);
    offer_at(110, 200, 10, 0);
    offer_at(0, 0, 0, 0);
    drain();

    set_own_tile(65535, 65535, 65535, 65535);
    offer_at(0, 65535, 65535, 65535);
    offer_at(65535, 0, 65535, 65535);
    offer_at(65535, 65535, 65535, 65535);
    drain();

    set_own_tile(300, 300, 0, 0);
    offer_at(300, 300, 1, 1);
    offer_at(299, 299, 1, 1);
    offer_at(290, 290, 20, 20);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: set_own_tile(1000, 2000, 16, 8);
        1: set_own_tile(0, 0, 65535, 65535);
        2: set_own_tile(65535, 65535, 1, 1);
        3: set_own_tile(0, 65535, 65535, 1);
        4: set_own_tile(CW'($urandom), CW'($urandom),
                        CW'($urandom_range(200, 1)), CW'($urandom_range(200, 1)));
        5: set_own_tile(CW'($urandom), CW'($urandom),
                        CW'($urandom_range(65535, 1)), CW'($urandom_range(65535, 1)));
        default: set_own_tile(40000, 30000, 300, 500);
      endcase
      case (phase % 3)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 20) hold_req = $urandom_range(250, 150);
        if (i == 60) drain();
        offer(random_neighbor());
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (halos.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/thof_pkg.sv
design/thof_fifo.sv
design/thof_front.sv
design/thof_back.sv
design/tile_halo_overlap_offset_top.sv
tb/testbench.sv
